[rtl/core/mrfc_pkg.sv]
package mrfc_pkg;

  localparam int unsigned CFG_IDX_W = 8;
  localparam int unsigned CFG_DATA_W = 64;

  localparam logic [CFG_IDX_W-1:0] CFG_HANDLER_CODES = 8'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_HANDLER_VALID = 8'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_FRAME_LEN = 8'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_REG_LEN   = 8'd3;

  localparam logic [15:0] CRC_POLY = 16'hA001;
  localparam logic [15:0] CRC_INIT = 16'hFFFF;

  // Address, function and CRC bytes
  localparam logic [3:0] FIXED_OVERHEAD = 4'd4;
  // Both register fields need bytes two through five
  localparam logic [3:0] REG_FIELDS_END = 4'd6;
  localparam logic [8:0] CRC_BYTES      = 9'd2;

  typedef enum logic [1:0] {
    ST_OK         = 2'd0,
    ST_TOO_SHORT  = 2'd1,
    ST_CRC_ERR    = 2'd2,
    ST_NO_HANDLER = 2'd3
  } status_t;

  typedef struct packed {
    logic [63:0] handler_codes;
    logic [7:0]  handler_valid;
    logic [3:0]  min_frame_len;
    logic [3:0]  min_reg_len;
  } cfg_t;

  // Frame summary handed from the accumulator to the result stage
  typedef struct packed {
    logic [15:0] crc_calc;
    logic [15:0] crc_recv;
    logic [8:0]  len;
    logic [7:0]  addr;
    logic [7:0]  func;
    logic [15:0] reg_addr;
    logic [15:0] reg_word;
  } frame_sum_t;

  typedef struct packed {
    status_t     status;
    logic [7:0]  slave_address;
    logic [7:0]  function_code;
    logic [2:0]  handler_index;
    logic [15:0] register_address;
    logic [15:0] register_word;
    logic        register_fields_valid;
    logic [7:0]  payload_length;
    logic [8:0]  frame_length;
  } result_t;

  // Reflected CRC-16, one byte, eight bit steps
  function automatic logic [15:0] crc16_feed(logic [15:0] crc, logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

endpackage

[rtl/core/mrfc_if.sv]
interface mrfc_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       frame_last;

  modport source (output valid, output data_byte, output frame_last, input ready);
  modport sink   (input valid, input data_byte, input frame_last, output ready);
endinterface

interface mrfc_out_if import mrfc_pkg::*; ();
  logic        valid;
  logic        ready;
  status_t     status;
  logic [7:0]  slave_address;
  logic [7:0]  function_code;
  logic [2:0]  handler_index;
  logic [15:0] register_address;
  logic [15:0] register_word;
  logic        register_fields_valid;
  logic [7:0]  payload_length;
  logic [8:0]  frame_length;

  modport source (
    output valid, output status, output slave_address, output function_code,
    output handler_index, output register_address, output register_word,
    output register_fields_valid, output payload_length, output frame_length,
    input ready
  );
  modport sink (
    input valid, input status, input slave_address, input function_code,
    input handler_index, input register_address, input register_word,
    input register_fields_valid, input payload_length, input frame_length,
    output ready
  );
endinterface

interface mrfc_cfg_if import mrfc_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

[rtl/core/mrfc_cfg_regs.sv]
module mrfc_cfg_regs import mrfc_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  mrfc_cfg_if.sink   cfg,
  output cfg_t       cfg_q
);

  cfg_t cfg_r;

  assign cfg.ready = 1'b1;
  assign cfg_q     = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.handler_codes <= '0;
      cfg_r.handler_valid <= '0;
      cfg_r.min_frame_len <= 4'd4;
      cfg_r.min_reg_len   <= 4'd8;
    end else if (cfg.valid) begin
      case (cfg.index)
        CFG_HANDLER_CODES: cfg_r.handler_codes <= cfg.data;
        CFG_HANDLER_VALID: cfg_r.handler_valid <= cfg.data[7:0];
        CFG_MIN_FRAME_LEN: cfg_r.min_frame_len <= cfg.data[3:0];
        CFG_MIN_REG_LEN:   cfg_r.min_reg_len   <= cfg.data[3:0];
        default: ;
      endcase
    end
  end

endmodule

[rtl/core/mrfc_frame_acc.sv]
module mrfc_frame_acc import mrfc_pkg::*; #(
  parameter int MAX_FRAME_LEN = 256
) (
  input  logic       clk,
  input  logic       rst_n,
  mrfc_in_if.sink    in_ch,
  input  logic       slot_free,
  output logic       sum_valid,
  output frame_sum_t sum
);

  localparam logic [8:0] MaxLen = 9'(MAX_FRAME_LEN);

  // Input register
  logic        s1_valid_r;
  logic [7:0]  s1_byte_r;
  logic        s1_last_r;

  // Per-frame state
  logic [15:0] crc_r, crc_nxt;
  logic [7:0]  dly0_r, dly1_r;
  logic [8:0]  cnt_r, cnt_nxt;
  logic [7:0]  addr_r, addr_nxt;
  logic [7:0]  func_r, func_nxt;
  logic [15:0] rega_r, rega_nxt;
  logic [15:0] regw_r, regw_nxt;

  logic advance;

  // A last byte needs the result slot; others always move on
  assign advance     = s1_valid_r && (!s1_last_r || slot_free);
  assign in_ch.ready = !s1_valid_r || advance;

  always_comb begin
    crc_nxt  = (cnt_r >= CRC_BYTES) ? crc16_feed(crc_r, dly1_r) : crc_r;
    cnt_nxt  = (cnt_r < MaxLen) ? cnt_r + 9'd1 : cnt_r;
    addr_nxt = addr_r;
    func_nxt = func_r;
    rega_nxt = rega_r;
    regw_nxt = regw_r;
    case (cnt_r)
      9'd0: addr_nxt = s1_byte_r;
      9'd1: func_nxt = s1_byte_r;
      9'd2: rega_nxt = {s1_byte_r, 8'h00};
      9'd3: rega_nxt = {rega_r[15:8], s1_byte_r};
      9'd4: regw_nxt = {s1_byte_r, 8'h00};
      9'd5: regw_nxt = {regw_r[15:8], s1_byte_r};
      default: ;
    endcase
  end

  assign sum_valid     = advance && s1_last_r;
  assign sum.crc_calc  = crc_nxt;
  assign sum.crc_recv  = {s1_byte_r, dly0_r};
  assign sum.len       = cnt_nxt;
  assign sum.addr      = addr_nxt;
  assign sum.func      = func_nxt;
  assign sum.reg_addr  = rega_nxt;
  assign sum.reg_word  = regw_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ch.ready) begin
      s1_valid_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.ready && in_ch.valid) begin
      s1_byte_r <= in_ch.data_byte;
      s1_last_r <= in_ch.frame_last;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || (advance && s1_last_r)) begin
      crc_r  <= CRC_INIT;
      dly0_r <= '0;
      dly1_r <= '0;
      cnt_r  <= '0;
      addr_r <= '0;
      func_r <= '0;
      rega_r <= '0;
      regw_r <= '0;
    end else if (advance) begin
      crc_r  <= crc_nxt;
      dly0_r <= s1_byte_r;
      dly1_r <= dly0_r;
      cnt_r  <= cnt_nxt;
      addr_r <= addr_nxt;
      func_r <= func_nxt;
      rega_r <= rega_nxt;
      regw_r <= regw_nxt;
    end
  end

endmodule

[rtl/core/mrfc_result.sv]
module mrfc_result import mrfc_pkg::*; #(
  parameter int MAX_HANDLERS = 8
) (
  input  logic       clk,
  input  logic       rst_n,
  input  cfg_t       cfg_q,
  input  logic       sum_valid,
  input  frame_sum_t sum,
  output logic       slot_free,
  mrfc_out_if.source out_ch
);

  logic    out_valid_r;
  result_t res_r, res_nxt;

  logic [3:0] min_len;
  logic [3:0] min_reg;
  logic       too_short;
  logic       found;
  logic [2:0] idx;
  status_t    st;

  assign slot_free = !out_valid_r || out_ch.ready;

  always_comb begin
    min_len   = (cfg_q.min_frame_len < FIXED_OVERHEAD) ? FIXED_OVERHEAD
                                                       : cfg_q.min_frame_len;
    min_reg   = (cfg_q.min_reg_len < REG_FIELDS_END) ? REG_FIELDS_END
                                                     : cfg_q.min_reg_len;
    too_short = sum.len < {5'd0, min_len};

    // Walk down so the lowest matching entry wins
    found = 1'b0;
    idx   = '0;
    for (int i = MAX_HANDLERS - 1; i >= 0; i--) begin
      if (cfg_q.handler_valid[i] && (cfg_q.handler_codes[8*i +: 8] == sum.func)) begin
        found = 1'b1;
        idx   = 3'(i);
      end
    end

    if (too_short) begin
      st = ST_TOO_SHORT;
    end else if (sum.crc_calc != sum.crc_recv) begin
      st = ST_CRC_ERR;
    end else if (!found) begin
      st = ST_NO_HANDLER;
    end else begin
      st = ST_OK;
    end

    res_nxt.status        = st;
    res_nxt.slave_address = too_short ? 8'h00 : sum.addr;
    res_nxt.function_code = (sum.len < CRC_BYTES) ? 8'h00 : sum.func;
    res_nxt.handler_index = (st == ST_OK) ? idx : 3'd0;
    if (sum.len >= {5'd0, min_reg}) begin
      res_nxt.register_address      = sum.reg_addr;
      res_nxt.register_word         = sum.reg_word;
      res_nxt.register_fields_valid = 1'b1;
    end else begin
      res_nxt.register_address      = '0;
      res_nxt.register_word         = '0;
      res_nxt.register_fields_valid = 1'b0;
    end
    res_nxt.payload_length = too_short ? 8'h00
                                       : 8'(sum.len - {5'd0, FIXED_OVERHEAD});
    res_nxt.frame_length   = sum.len;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (slot_free) begin
      out_valid_r <= sum_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (slot_free && sum_valid) begin
      res_r <= res_nxt;
    end
  end

  assign out_ch.valid                 = out_valid_r;
  assign out_ch.status                = res_r.status;
  assign out_ch.slave_address         = res_r.slave_address;
  assign out_ch.function_code         = res_r.function_code;
  assign out_ch.handler_index         = res_r.handler_index;
  assign out_ch.register_address      = res_r.register_address;
  assign out_ch.register_word         = res_r.register_word;
  assign out_ch.register_fields_valid = res_r.register_fields_valid;
  assign out_ch.payload_length        = res_r.payload_length;
  assign out_ch.frame_length          = res_r.frame_length;

endmodule

[rtl/core/modbus_rtu_frame_checker_unit.sv]
// Channel    Dir  Payload                                         Transfer
// in_port    in   data_byte, frame_last                           valid & ready
// out_port   out  status, header, register fields, lengths        valid & ready
// cfg_port   in   index, data (register write)                    valid & ready
//
// One byte per cycle sustained while no final byte waits for the result slot. A byte
// is held in the input register; the final byte of a frame is then folded into the
// result register, which drives out_port, once the result slot is free.
// The result register separates the two sides: a waiting result only stalls
// the next final byte, ordinary bytes keep flowing.
// rst_n (synchronous, active low) clears config to defaults and all frame state.
module modbus_rtu_frame_checker_unit import mrfc_pkg::*; #(
  parameter int MAX_HANDLERS  = 8,
  parameter int MAX_FRAME_LEN = 256
) (
  input  logic       clk,
  input  logic       rst_n,
  mrfc_in_if.sink    in_port,
  mrfc_out_if.source out_port,
  mrfc_cfg_if.sink   cfg_port
);

  // Register file; the user must write it only while no frame is in flight (not enforced here)
  cfg_t       cfg_q;

  // Frame summary from the accumulator, valid on the cycle a last byte retires
  logic       sum_valid;
  frame_sum_t sum;

  // Result slot free: empty, or its result is being transferred this cycle
  logic       slot_free;

  mrfc_cfg_regs u_cfg (
    .clk   (clk),
    .rst_n (rst_n),
    .cfg   (cfg_port),
    .cfg_q (cfg_q)
  );

  // Input register, CRC over all but the trailing two bytes (held in a
  // two-byte delay line), header capture and saturating byte count
  mrfc_frame_acc #(
    .MAX_FRAME_LEN (MAX_FRAME_LEN)
  ) u_acc (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_port),
    .slot_free (slot_free),
    .sum_valid (sum_valid),
    .sum       (sum)
  );

  // Status priority: too short, then CRC mismatch, then no handler.
  // Handler lookup picks the lowest valid entry whose code matches.
  mrfc_result #(
    .MAX_HANDLERS (MAX_HANDLERS)
  ) u_res (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_q     (cfg_q),
    .sum_valid (sum_valid),
    .sum       (sum),
    .slot_free (slot_free),
    .out_ch    (out_port)
  );

endmodule
